// File: rtl/albm_pkg.sv
package albm_pkg;

  localparam int ADC_BITS = 12;

  localparam int TICK_W   = 32;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 4;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int IN_BITS  = TICK_W + 1 + ADC_BITS;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + SUM_W + 1 + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic signed [15:0] THRESH_RESET   = 16'sd734;
  localparam logic [CNT_W-1:0]   SPA_RESET      = 4'd10;
  localparam logic [TICK_W-1:0]  INTERVAL_RESET = 32'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD       = 2'd0,
    CFG_SAMPLES_PER_AVERAGE = 2'd1,
    CFG_MEASURE_INTERVAL    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_EVAL   = 2'd0,
    PH_START  = 2'd1,
    PH_RESULT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_EVAL    = 2'd1,
    ACT_STARTED = 2'd2,
    ACT_SAMPLE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic commit;
  } albm_cmd_t;

  typedef struct packed {
    logic do_eval;
    logic out_free;
  } albm_sts_t;

endpackage

// File: rtl/albm_ctrl.sv
module albm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  albm_pkg::albm_sts_t sts,
  output albm_pkg::albm_cmd_t cmd
);

  albm_pkg::ctrl_state_t state, state_next;
  logic [albm_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= albm_pkg::ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      albm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = albm_pkg::ST_EXEC;
        end
      end
      albm_pkg::ST_EXEC: begin
        if (sts.do_eval) begin
          cmd.div_start = 1'b1;
          div_cnt_next  = '0;
          state_next    = albm_pkg::ST_DIV;
        end else begin
          state_next = albm_pkg::ST_WRITE;
        end
      end
      albm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == albm_pkg::DIV_CNT_W'(albm_pkg::DIV_STEPS - 1)) begin
          state_next = albm_pkg::ST_WRITE;
        end
      end
      albm_pkg::ST_WRITE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = albm_pkg::ST_IDLE;
        end
      end
      default: state_next = albm_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/albm_dp.sv
module albm_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [albm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [albm_pkg::CFG_W-1:0]             cfg_data,
  input  logic [albm_pkg::TICK_W-1:0]            in_tick_now,
  input  logic                                   in_sound_busy,
  input  logic signed [albm_pkg::ADC_BITS-1:0]   in_adc_sample,
  input  albm_pkg::albm_cmd_t                    cmd,
  output albm_pkg::albm_sts_t                    sts,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [1:0]                             out_action,
  output logic                                   out_low_battery,
  output logic signed [albm_pkg::SUM_W-1:0]      out_average_value,
  output logic                                   out_adc_power,
  output logic                                   out_sense_drive
);

  logic signed [15:0]              low_threshold;
  logic [albm_pkg::CNT_W-1:0]      samples_per_average;
  logic [albm_pkg::TICK_W-1:0]     measure_interval;

  albm_pkg::phase_t                phase;
  logic [albm_pkg::TICK_W-1:0]     next_measure_time;
  logic [albm_pkg::SUM_W-1:0]      sample_sum;
  logic [albm_pkg::CNT_W-1:0]      sample_count;
  logic [albm_pkg::SUM_W-1:0]      last_average;

  logic [albm_pkg::TICK_W-1:0]     tick_now;
  logic                            sound_busy;
  logic signed [albm_pkg::ADC_BITS-1:0] adc_sample;

  logic [albm_pkg::SUM_W-1:0]      quo;
  logic [albm_pkg::CNT_W-1:0]      rem;
  logic [albm_pkg::CNT_W-1:0]      divisor;
  logic [albm_pkg::CNT_W:0]        trial;
  logic                            trial_ok;

  logic                            active;
  logic [albm_pkg::SUM_W-1:0]      sample_ext;
  logic [albm_pkg::CNT_W-1:0]      count_inc;
  albm_pkg::phase_t                phase_next;
  logic [albm_pkg::TICK_W-1:0]     next_measure_time_next;
  logic [albm_pkg::SUM_W-1:0]      sample_sum_next;
  logic [albm_pkg::CNT_W-1:0]      sample_count_next;
  logic [albm_pkg::SUM_W-1:0]      last_average_next;
  logic [1:0]                      action_next;
  logic                            alarm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold       <= albm_pkg::THRESH_RESET;
      samples_per_average <= albm_pkg::SPA_RESET;
      measure_interval    <= albm_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        albm_pkg::CFG_LOW_THRESHOLD:       low_threshold <= signed'(cfg_data[15:0]);
        albm_pkg::CFG_SAMPLES_PER_AVERAGE:
          samples_per_average <= cfg_data[albm_pkg::CNT_W-1:0];
        albm_pkg::CFG_MEASURE_INTERVAL:
          measure_interval <= cfg_data[albm_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick_now   <= in_tick_now;
      sound_busy <= in_sound_busy;
      adc_sample <= in_adc_sample;
    end
  end

  assign divisor  = (sample_count == '0) ? albm_pkg::CNT_W'(1) : sample_count;
  assign trial    = {rem, quo[albm_pkg::SUM_W-1]};
  assign trial_ok = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= sample_sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[albm_pkg::SUM_W-2:0], trial_ok};
      rem <= trial_ok ? albm_pkg::CNT_W'(trial - {1'b0, divisor})
                      : trial[albm_pkg::CNT_W-1:0];
    end
  end

  assign active       = !sound_busy && (next_measure_time <= tick_now);
  assign sts.do_eval  = active && (phase == albm_pkg::PH_EVAL);
  assign sts.out_free = !out_valid || out_ready;

  assign sample_ext = albm_pkg::SUM_W'(adc_sample);
  assign count_inc  = sample_count + 1'b1;

  always_comb begin
    phase_next             = phase;
    next_measure_time_next = next_measure_time;
    sample_sum_next        = sample_sum;
    sample_count_next      = sample_count;
    last_average_next      = last_average;
    action_next            = albm_pkg::ACT_IDLE;
    alarm_next             = 1'b0;
    if (active) begin
      unique case (phase)
        albm_pkg::PH_EVAL: begin
          last_average_next      = quo;
          alarm_next             = signed'(quo) < low_threshold;
          phase_next             = albm_pkg::PH_START;
          next_measure_time_next = tick_now + measure_interval;
          sample_sum_next        = '0;
          sample_count_next      = '0;
          action_next            = albm_pkg::ACT_EVAL;
        end
        albm_pkg::PH_RESULT: begin
          sample_sum_next   = sample_sum + sample_ext;
          sample_count_next = count_inc;
          phase_next        = (count_inc >= samples_per_average) ? albm_pkg::PH_EVAL
                                                                 : albm_pkg::PH_START;
          action_next       = albm_pkg::ACT_SAMPLE;
        end
        default: begin
          phase_next  = albm_pkg::PH_RESULT;
          action_next = albm_pkg::ACT_STARTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= albm_pkg::PH_START;
      next_measure_time <= '0;
      sample_sum        <= '0;
      sample_count      <= '0;
      last_average      <= '0;
    end else if (cmd.commit) begin
      phase             <= phase_next;
      next_measure_time <= next_measure_time_next;
      sample_sum        <= sample_sum_next;
      sample_count      <= sample_count_next;
      last_average      <= last_average_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action        <= action_next;
      out_low_battery   <= alarm_next;
      out_average_value <= signed'(last_average_next);
      out_adc_power     <= (phase_next == albm_pkg::PH_RESULT);
      out_sense_drive   <= (phase_next == albm_pkg::PH_RESULT);
    end
  end

endmodule

// File: rtl/averaged_low_battery_monitor_core.sv
// A beat that takes no evaluation passes from capture through the execute and write states;
// an evaluating beat also runs the 16-step restoring divider. The write waits until the output
// register is free, and a new beat is accepted only after the previous one has been written.
// The next beat is accepted while the previous result still waits in the output register.
// Synchronous active-high reset loads the register defaults, puts the sequencer in the
// start phase, clears the accumulator, count, average and next measure time.
module averaged_low_battery_monitor_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [albm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [albm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0: tick_now[31:0], sound_busy, adc_sample, zero fill.
  input  logic [albm_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0: low_battery, average_value[15:0], adc_power, sense_drive, zero fill.
  output logic [albm_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Fields from bit 0: action[1:0].
  output logic [1:0]                          m_tuser
);

  albm_pkg::albm_cmd_t cmd;
  albm_pkg::albm_sts_t sts;

  logic                                 low_battery;
  logic signed [albm_pkg::SUM_W-1:0]    average_value;
  logic                                 adc_power;
  logic                                 sense_drive;

  albm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  albm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_tick_now       (s_tdata[albm_pkg::TICK_W-1:0]),
    .in_sound_busy     (s_tdata[albm_pkg::TICK_W]),
    .in_adc_sample     (signed'(s_tdata[albm_pkg::TICK_W+albm_pkg::ADC_BITS:albm_pkg::TICK_W+1])),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (m_tready),
    .out_valid         (m_tvalid),
    .out_action        (m_tuser),
    .out_low_battery   (low_battery),
    .out_average_value (average_value),
    .out_adc_power     (adc_power),
    .out_sense_drive   (sense_drive)
  );

  assign m_tdata = albm_pkg::OUT_DATA_W'({sense_drive, adc_power, average_value, low_battery});

endmodule

// File: rtl/albm_checker.sv
module albm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [albm_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [1:0]                          m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat present right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat accepted while one is in progress");

  a_alarm_on_eval: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != albm_pkg::ACT_EVAL) |-> !m_tdata[0])
    else $error("alarm raised on a beat that did not evaluate");

  a_power_sense: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17] == m_tdata[18]))
    else $error("converter power and sense drive disagree");

endmodule

bind averaged_low_battery_monitor_core albm_checker u_albm_checker (.*);

// File: tb/averaged_low_battery_monitor_core_test.sv
module averaged_low_battery_monitor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import albm_pkg::*;

  typedef struct {
    action_t     action;
    logic        low_battery;
    logic [15:0] average_value;
    logic        adc_power;
    logic        sense_drive;
  } battery_report_t;

  class battery_scoreboard;
    logic signed [15:0] threshold;
    logic [3:0]         burst_len;
    logic [31:0]        interval;
    phase_t             phase;
    logic [31:0]        next_time;
    logic [15:0]        sum;
    logic [3:0]         count;
    logic [15:0]        average;
    battery_report_t    reports[$];
    int                 errors;

    function new();
      threshold = THRESH_RESET;
      burst_len = SPA_RESET;
      interval = INTERVAL_RESET;
      phase = PH_START;
      next_time = '0;
      sum = '0;
      count = '0;
      average = '0;
      errors = 0;
    endfunction

    function void configure(cfg_index_t idx, logic [31:0] value);
      case (idx)
        CFG_LOW_THRESHOLD: threshold = value[15:0];
        CFG_SAMPLES_PER_AVERAGE: burst_len = value[3:0];
        CFG_MEASURE_INTERVAL: interval = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return reports.size();
    endfunction

    function void note_step(logic [31:0] tick, logic busy, logic [11:0] sample);
      battery_report_t r;
      logic [15:0] divisor;
      r.action = ACT_IDLE;
      r.low_battery = 1'b0;
      if (!busy && next_time <= tick) begin
        case (phase)
          PH_EVAL: begin
            divisor = (count == 0) ? 16'd1 : {12'd0, count};
            average = sum / divisor;
            r.low_battery = $signed(average) < threshold;
            phase = PH_START;
            next_time = tick + interval;
            sum = '0;
            count = '0;
            r.action = ACT_EVAL;
          end
          PH_RESULT: begin
            sum = sum + {{4{sample[11]}}, sample};
            count = count + 4'd1;
            phase = (count >= burst_len) ? PH_EVAL : PH_START;
            r.action = ACT_SAMPLE;
          end
          default: begin
            phase = PH_RESULT;
            r.action = ACT_STARTED;
          end
        endcase
      end
      r.average_value = average;
      r.adc_power = (phase == PH_RESULT);
      r.sense_drive = (phase == PH_RESULT);
      reports.push_back(r);
    endfunction

    function void check_result(logic [1:0] action, logic [OUT_DATA_W-1:0] data);
      battery_report_t r;
      if (reports.size() == 0) begin
        $error("unexpected result beat: action %0d data %h", action, data);
        errors++;
        return;
      end
      r = reports.pop_front();
      if (action !== r.action) begin
        $error("action: expected %0d, got %0d", r.action, action);
        errors++;
      end
      if (data[0] !== r.low_battery) begin
        $error("low_battery: expected %0d, got %0d", r.low_battery, data[0]);
        errors++;
      end
      if (data[16:1] !== r.average_value) begin
        $error("average_value: expected %0d, got %0d",
               $signed(r.average_value), $signed(data[16:1]));
        errors++;
      end
      if (data[17] !== r.adc_power) begin
        $error("adc_power: expected %0d, got %0d", r.adc_power, data[17]);
        errors++;
      end
      if (data[18] !== r.sense_drive) begin
        $error("sense_drive: expected %0d, got %0d", r.sense_drive, data[18]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  battery_scoreboard sb;
  int  send_gap_max;
  int  take_gap_max;
  bit  hold_request;

  averaged_low_battery_monitor_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("averaged_low_battery_monitor_core test failed");
    $finish;
  end

  task automatic send_step(logic [31:0] tick, logic busy, logic [11:0] sample);
    int n;
    logic [IN_DATA_W-1:0] beat;
    n = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    beat = '0;
    beat[31:0] = tick;
    beat[32] = busy;
    beat[44:33] = sample;
    s_tdata <= beat;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_step(tick, busy, sample);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] thr, logic [3:0] spa, logic [31:0] ivl);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOW_THRESHOLD;
    cfg_data <= {{16{thr[15]}}, thr};
    @(negedge clk);
    cfg_index <= CFG_SAMPLES_PER_AVERAGE;
    cfg_data <= {28'd0, spa};
    @(negedge clk);
    cfg_index <= CFG_MEASURE_INTERVAL;
    cfg_data <= ivl;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.configure(CFG_LOW_THRESHOLD, {{16{thr[15]}}, thr});
    sb.configure(CFG_SAMPLES_PER_AVERAGE, {28'd0, spa});
    sb.configure(CFG_MEASURE_INTERVAL, ivl);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    bit held;
    m_tready = 1'b0;
    held = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      n = (take_gap_max > 0) ? $urandom_range(0, take_gap_max) : 0;
      if (hold_request && !held) begin
        held = 1'b1;
        n = 300;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tuser, m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] tick;
    logic [31:0] tick_base;
    logic [15:0] thr;
    logic [3:0]  spa;
    logic [31:0] ivl;
    int r;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_LOW_THRESHOLD;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_request = 1'b0;
    send_gap_max = 0;
    take_gap_max = 0;
    sb = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a blocked step, extreme samples with a negative sum, a wrapping tick.
    send_step(32'h0, 1'b1, 12'h000);
    send_step(32'hFFFF_FFFF, 1'b0, 12'h7FF);
    send_step(32'h0, 1'b0, 12'h7FF);
    send_step(32'h1, 1'b0, 12'h800);
    send_step(32'h2, 1'b0, 12'h800);
    send_step(32'h3, 1'b1, 12'hFFF);
    settle();

    // Lower the burst length below the count already reached.
    set_config(16'd734, 4'd1, 32'd60000);
    send_step(32'h4, 1'b0, 12'h000);
    send_step(32'h5, 1'b0, 12'h7FF);
    send_step(32'hFFFF_FFF0, 1'b0, 12'h000);
    send_step(32'd59983, 1'b0, 12'h000);
    send_step(32'd59984, 1'b0, 12'h000);
    send_step(32'd59985, 1'b0, 12'h800);
    send_step(32'd60000, 1'b0, 12'h000);
    settle();

    // Zero burst length, lowest threshold and the largest interval.
    set_config(16'h8000, 4'd0, 32'hFFFF_FFFF);
    send_step(32'd120000, 1'b0, 12'h000);
    send_step(32'd120001, 1'b0, 12'h000);
    send_step(32'h8000_0000, 1'b0, 12'h000);
    send_step(32'h7FFF_FFFE, 1'b0, 12'h000);
    send_step(32'h7FFF_FFFF, 1'b0, 12'h000);
    send_step(32'h8000_0000, 1'b0, 12'h555);
    send_step(32'hFFFF_FFFF, 1'b0, 12'hAAA);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        thr = 16'h7FFF;
        spa = 4'd15;
        ivl = 32'd0;
      end else begin
        case ($urandom_range(0, 5))
          0: thr = 16'h8000;
          1: thr = 16'h7FFF;
          default: thr = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0: spa = 4'd0;
          1: spa = 4'd15;
          2: spa = 4'd1;
          default: spa = 4'($urandom_range(2, 14));
        endcase
        case ($urandom_range(0, 5))
          0: ivl = 32'd0;
          1: ivl = 32'hFFFF_FFFF;
          2: ivl = $urandom;
          default: ivl = $urandom_range(1, 400);
        endcase
      end
      set_config(thr, spa, ivl);
      send_gap_max = (ph % 3 == 1 || ph == 4) ? 0 : 9;
      take_gap_max = (ph % 4 == 2) ? 0 : 9;
      tick_base = sb.next_time;

      for (int i = 0; i < 150; i++) begin
        if (ph == 4 && i == 20) hold_request = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 8) begin
          tick = $urandom;
        end else if (r < 14) begin
          tick = sb.next_time - 32'd1;
        end else if (r < 24) begin
          tick = sb.next_time + $urandom_range(0, 2);
          tick_base = tick;
        end else begin
          tick_base = tick_base + $urandom_range(0, 150);
          tick = tick_base;
        end
        send_step(tick, ($urandom_range(0, 9) == 0), 12'($urandom_range(0, 4095)));
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("averaged_low_battery_monitor_core test passed");
    end else begin
      $display("averaged_low_battery_monitor_core test failed");
    end
    $finish;
  end

endmodule
